// ===== rtl/ttps_pkg.sv =====
package ttps_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  // field widths
  localparam int OP_W          = 2;
  localparam int KEY_W         = 64;
  localparam int PLY_W         = 6;
  localparam int DEPTH_W       = 6;
  localparam int SCORE_W       = 16;
  localparam int MOVE_W        = 32;
  localparam int BOUND_W       = 2;
  localparam int STAT_W        = 32;
  localparam int NUM_ENTRIES_W = 17;
  localparam int THR_W         = 15;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  // opcodes
  localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // bound kinds
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MOVE  = 2'd2;

  // config reset values
  localparam logic [NUM_ENTRIES_W-1:0] NUM_ENTRIES_RST = 17'd65536;
  localparam logic [THR_W-1:0]         MATE_THR_RST    = 15'd29936;
  localparam logic [MOVE_W-1:0]        EMPTY_MOVE_RST  = '0;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [BOUND_W-1:0]        bound;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // request to the key modulo unit
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

endpackage

// ===== rtl/transposition_table_probe_store_core.sv =====
// probe, move probe and store pass from acceptance through the key modulo (one
// bit per cycle), ram read, evaluate and finish; a new word is taken only once
// the last is finished; clear empties the first effective-entry-count entries, then finishes
// reset: synchronous; afterwards a pass writes every table entry
// to empty before the input is ready (config writes are taken during the pass)
module transposition_table_probe_store_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // config write port
  input  logic                                   cfg_we,
  input  logic [ttps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ttps_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input words
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [ttps_pkg::OP_W-1:0]              opcode,
  input  logic [ttps_pkg::KEY_W-1:0]             pos_key,
  input  logic [ttps_pkg::PLY_W-1:0]             ply,
  input  logic [ttps_pkg::DEPTH_W-1:0]           search_depth,
  input  logic signed [ttps_pkg::SCORE_W-1:0]    alpha_bound,
  input  logic signed [ttps_pkg::SCORE_W-1:0]    beta_bound,
  input  logic [ttps_pkg::MOVE_W-1:0]            move_in,
  input  logic signed [ttps_pkg::SCORE_W-1:0]    score_in,
  input  logic [ttps_pkg::BOUND_W-1:0]           bound_kind,
  // result words
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   key_matched,
  output logic                                   cutoff,
  output logic [ttps_pkg::MOVE_W-1:0]            move_out,
  output logic signed [ttps_pkg::SCORE_W-1:0]    score_out,
  output logic [ttps_pkg::STAT_W-1:0]            hit_count,
  output logic [ttps_pkg::STAT_W-1:0]            new_write_count,
  output logic [ttps_pkg::STAT_W-1:0]            overwrite_count
);
  import ttps_pkg::*;

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;  // clearing sweep
  localparam logic [2:0] S_IDLE = 3'd1;  // waiting for a word
  localparam logic [2:0] S_DIV  = 3'd2;  // key modulo in progress
  localparam logic [2:0] S_READ = 3'd3;  // ram read issued
  localparam logic [2:0] S_EVAL = 3'd4;  // entry compare and mate adjust
  localparam logic [2:0] S_FIN  = 3'd5;  // window check, counters, write back

  localparam int SW = SCORE_W + 1;  // score math width, room for ply adjust
  localparam logic signed [SW-1:0] SAT_HI = 17'sd32767;
  localparam logic signed [SW-1:0] SAT_LO = -17'sd32768;

  logic [2:0] state;

  // config registers
  logic [NUM_ENTRIES_W-1:0] num_entries;
  logic [THR_W-1:0]         mate_threshold;
  logic [MOVE_W-1:0]        empty_move;

  // statistics
  logic [STAT_W-1:0] hits, hits_next;
  logic [STAT_W-1:0] new_writes, new_writes_next;
  logic [STAT_W-1:0] overwrites, overwrites_next;

  // clearing sweep
  logic [ADDR_W-1:0] clr_idx;
  logic [ADDR_W-1:0] clr_end;
  logic              clr_init;  // sweep after reset writes a zero move

  // captured request
  logic [OP_W-1:0]           req_op;
  logic [KEY_W-1:0]          req_key;
  logic [PLY_W-1:0]          req_ply;
  logic [DEPTH_W-1:0]        req_depth;
  logic signed [SCORE_W-1:0] req_alpha;
  logic signed [SCORE_W-1:0] req_beta;
  logic [MOVE_W-1:0]         req_move;
  logic signed [SCORE_W-1:0] req_score;
  logic [BOUND_W-1:0]        req_kind;

  // evaluate stage registers
  logic                      ev_match;
  logic                      ev_empty;
  logic                      ev_depth_ok;
  logic [MOVE_W-1:0]         ev_move;
  logic signed [SCORE_W-1:0] ev_score;  // ply adjusted stored score
  logic [BOUND_W-1:0]        ev_bound;
  logic signed [SCORE_W-1:0] st_score;  // score to write on store

  // live entry count: zero acts as one, saturates at table depth
  logic [CNT_W-1:0] live;
  always_comb begin
    if (num_entries == '0) begin
      live = CNT_W'(1);
    end else if (int'(num_entries) > TABLE_DEPTH) begin
      live = CNT_W'(TABLE_DEPTH);
    end else begin
      live = CNT_W'(num_entries);
    end
  end

  // key modulo unit
  mod_req_t          mod_req;
  logic              mod_done;
  logic [ADDR_W-1:0] index;

  logic in_fire;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    mod_req.start   = in_fire && (opcode != OP_CLEAR);
    mod_req.key     = pos_key;
    mod_req.divisor = live;
  end

  ttps_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .done (mod_done),
    .rem  (index)
  );

  // entry store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd;
  entry_t            clr_entry;
  entry_t            st_entry;
  logic              fin_go;

  assign rd = entry_t'(ram_rdata);

  always_comb begin
    clr_entry.key   = '0;
    clr_entry.move  = clr_init ? EMPTY_MOVE_RST : empty_move;
    clr_entry.score = '0;
    clr_entry.depth = '0;
    clr_entry.bound = '0;
    st_entry.key    = req_key;
    st_entry.move   = req_move;
    st_entry.score  = st_score;
    st_entry.depth  = req_depth;
    st_entry.bound  = req_kind;
    ram_we    = (state == S_CLR) || (fin_go && (req_op == OP_STORE));
    ram_addr  = (state == S_CLR) ? clr_idx : index;
    ram_wdata = (state == S_CLR) ? clr_entry : st_entry;
  end

  ttps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // mate score adjust, both directions
  logic signed [SW-1:0] thr_pos, thr_neg, ply_ext;
  logic signed [SW-1:0] ent_s, ent_adj;
  logic signed [SW-1:0] new_s, new_adj;

  always_comb begin
    thr_pos = $signed({{(SW - THR_W){1'b0}}, mate_threshold});
    thr_neg = -thr_pos;
    ply_ext = $signed({{(SW - PLY_W){1'b0}}, req_ply});
    ent_s   = SW'(rd.score);
    new_s   = SW'(req_score);
    // probe: pull mate scores toward the root
    if (ent_s > thr_pos) begin
      ent_adj = ent_s - ply_ext;
    end else if (ent_s < thr_neg) begin
      ent_adj = ent_s + ply_ext;
    end else begin
      ent_adj = ent_s;
    end
    // store: push mate scores away from the root, then saturate
    if (new_s > thr_pos) begin
      new_adj = new_s + ply_ext;
    end else if (new_s < thr_neg) begin
      new_adj = new_s - ply_ext;
    end else begin
      new_adj = new_s;
    end
    if (new_adj > SAT_HI) begin
      new_adj = SAT_HI;
    end else if (new_adj < SAT_LO) begin
      new_adj = SAT_LO;
    end
  end

  // finish: window check and statistics
  logic                      r_match;
  logic                      r_cut;
  logic [MOVE_W-1:0]         r_move;
  logic signed [SCORE_W-1:0] r_score;

  always_comb begin
    fin_go          = (state == S_FIN) && (!out_valid || out_ready);
    hits_next       = hits;
    new_writes_next = new_writes;
    overwrites_next = overwrites;
    r_match         = 1'b0;
    r_cut           = 1'b0;
    r_move          = empty_move;
    r_score         = '0;
    unique case (req_op)
      OP_PROBE: begin
        r_match = ev_match;
        if (ev_match) begin
          r_move = ev_move;
          if (ev_depth_ok) begin
            hits_next = hits + 1'b1;
            r_score   = ev_score;
            case (ev_bound)
              BOUND_UPPER: begin
                if (ev_score <= req_alpha) begin
                  r_score = req_alpha;
                  r_cut   = 1'b1;
                end
              end
              BOUND_LOWER: begin
                if (ev_score >= req_beta) begin
                  r_score = req_beta;
                  r_cut   = 1'b1;
                end
              end
              BOUND_EXACT: r_cut = 1'b1;
              default: ;  // unused kind never cuts
            endcase
          end
        end
      end
      OP_MOVE: begin
        r_match = ev_match;
        if (ev_match) begin
          r_move = ev_move;
        end
      end
      OP_STORE: begin
        r_match = ev_match;
        if (ev_empty) begin
          new_writes_next = new_writes + 1'b1;
        end else begin
          overwrites_next = overwrites + 1'b1;
        end
      end
      OP_CLEAR: new_writes_next = '0;
      default: ;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_entries    <= NUM_ENTRIES_RST;
      mate_threshold <= MATE_THR_RST;
      empty_move     <= EMPTY_MOVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ENTRIES: num_entries    <= cfg_data[NUM_ENTRIES_W-1:0];
        CFG_MATE_THR:    mate_threshold <= cfg_data[THR_W-1:0];
        CFG_EMPTY_MOVE:  empty_move     <= cfg_data[MOVE_W-1:0];
        default: ;  // no register at this index
      endcase
    end
  end

  // sequencer, statistics and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      clr_end    <= ADDR_W'(TABLE_DEPTH - 1);
      clr_init   <= 1'b1;
      hits       <= '0;
      new_writes <= '0;
      overwrites <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == clr_end) begin
            state    <= clr_init ? S_IDLE : S_FIN;
            clr_init <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (opcode == OP_CLEAR) begin
              state   <= S_CLR;
              clr_idx <= '0;
              clr_end <= ADDR_W'(live - 1'b1);
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (mod_done) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            state      <= S_IDLE;
            out_valid  <= 1'b1;
            hits       <= hits_next;
            new_writes <= new_writes_next;
            overwrites <= overwrites_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op    <= opcode;
      req_key   <= pos_key;
      req_ply   <= ply;
      req_depth <= search_depth;
      req_alpha <= alpha_bound;
      req_beta  <= beta_bound;
      req_move  <= move_in;
      req_score <= score_in;
      req_kind  <= bound_kind;
    end
    if (state == S_EVAL) begin
      ev_match    <= (rd.key == req_key);
      ev_empty    <= (rd.key == '0);
      ev_depth_ok <= (rd.depth >= req_depth);
      ev_move     <= rd.move;
      ev_score    <= ent_adj[SCORE_W-1:0];
      ev_bound    <= rd.bound;
      st_score    <= new_adj[SCORE_W-1:0];
    end
    if (fin_go) begin
      key_matched     <= r_match;
      cutoff          <= r_cut;
      move_out        <= r_move;
      score_out       <= r_score;
      hit_count       <= hits_next;
      new_write_count <= new_writes_next;
      overwrite_count <= overwrites_next;
    end
  end

endmodule

// ===== rtl/ttps_ram.sv =====
module ttps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ttps_mod.sv =====
module ttps_mod (
  input  logic                           clk,
  input  logic                           rst,
  input  ttps_pkg::mod_req_t             req,
  output logic                           done,
  output logic [ttps_pkg::ADDR_W-1:0]    rem
);
  import ttps_pkg::*;

  localparam int STEP_W = $clog2(KEY_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [KEY_W-1:0]   dividend;
  logic [CNT_W-1:0]   divisor;
  logic [ADDR_W:0]    trial;
  logic [ADDR_W:0]    diff;
  logic               fits;

  // one quotient bit per cycle, restoring form
  always_comb begin
    trial = {rem, dividend[KEY_W-1]};
    fits  = ({{(ADDR_W + 1 - CNT_W){1'b0}}, divisor} <= trial);
    diff  = trial - {{(ADDR_W + 1 - CNT_W){1'b0}}, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= req.key;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      dividend <= {dividend[KEY_W-2:0], 1'b0};
      rem      <= fits ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
    end
  end

endmodule

// ===== rtl/ttps_chk.sv =====
module ttps_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                key_matched,
  input logic                                cutoff,
  input logic [ttps_pkg::MOVE_W-1:0]         move_out,
  input logic signed [ttps_pkg::SCORE_W-1:0] score_out
);
  import ttps_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(move_out) && $stable(score_out))
    else $error("result word changed while stalled");

  // one word at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after acceptance");

  // clearing sweep follows reset
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready or result during reset sweep");

  // a cutoff needs a key match
  a_cut_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && cutoff |-> key_matched)
    else $error("cutoff without key match");

  // a miss carries no score
  a_miss_score: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_matched |-> score_out == '0 && !cutoff)
    else $error("score on a miss");

endmodule

bind transposition_table_probe_store_core ttps_chk u_ttps_chk (.*);
